>>> hdl/rob_pkg.sv
// rob_pkg: shared types and constants of the in-order release reorder buffer
// used by rob_cell, the top level and the port checker; no dependencies

package rob_pkg;

  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned HDL_W       = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_RELEASED = 2'd0;
  localparam status_t ST_DUP      = 2'd1;
  localparam status_t ST_BEYOND   = 2'd2;

  // broadcast to every cell of the ring
  typedef struct packed {
    logic shift;  // rotate the ring by one position toward the head
    logic park;   // store the parked handle in the cell at park_pos
  } rob_ctl_t;

endpackage

>>> hdl/in_order_release_reorder_buffer.sv
// in_order_release_reorder_buffer: top level, ring of rob_cell slots plus sequencer
// depends on rob_pkg and rob_cell
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | seq_number, chunk_handle
//   out_    | output    | out_valid/out_stall | released_handle, released_seq,
//           |           |                   | status, last_of_run
//
// an item passes through an evaluate state, then a drain state that releases the run of
// chunks from the ring one by one, then a closing step in which the next item can already
// transfer. when the sequence number wraps with a window that is not a power of two,
// the ring rotates until its head lines up with the new slot.
// reset clears all slot valid bits at once; there is no clearing pass.
// a stalled output holds the sequencer once a second result is waiting.

module in_order_release_reorder_buffer #(
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rob_pkg::SEQ_W-1:0]       in_seq_number,
  input  logic [rob_pkg::HDL_W-1:0]       in_chunk_handle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rob_pkg::HDL_W-1:0]       out_released_handle,
  output logic [rob_pkg::SEQ_W-1:0]       out_released_seq,
  output logic [rob_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_last_of_run
);

  import rob_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SEQ_W-1:0]       it_seq_r;
  logic [HANDLE_BITS-1:0] it_hdl_r;
  logic [SEQ_W-1:0]       ne_r;
  logic [SLOT_W-1:0]      ne_slot_r, ne_slot_nxt;
  logic [SLOT_W-1:0]      head_slot_r, head_slot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   pend_vld_r;
  logic [HANDLE_BITS-1:0] pend_hdl_r;
  logic [SEQ_W-1:0]       pend_seq_r;
  status_t                pend_st_r;

  logic                   out_valid_r;
  logic [HDL_W-1:0]       out_hdl_r;
  logic [SEQ_W-1:0]       out_seq_r;
  status_t                out_st_r;
  logic                   out_last_r;

  logic [HANDLE_BITS+HDL_W-1:0] in_hdl_ext;
  logic [HANDLE_BITS-1:0]       in_hdl_k;
  logic [HDL_W+HANDLE_BITS-1:0] pend_hdl_ext;

  logic                   in_fire;
  logic                   out_free;
  logic                   go;
  logic [SEQ_W-1:0]       ahead;
  logic                   in_win;
  logic                   wrapped;
  logic [SLOT_W:0]        pos_diff;
  logic [SLOT_W:0]        pos_wrap;
  logic [SLOT_W-1:0]      pos;
  logic                   dup;
  logic                   aligned;
  logic                   head_vld;
  logic                   run_more;
  logic                   can_close;

  logic                   produce;
  logic                   finish;
  logic                   advance;
  logic                   shift;
  logic                   park;
  logic                   clr_head;
  logic [HANDLE_BITS-1:0] res_hdl;
  logic [SEQ_W-1:0]       res_seq;
  status_t                res_st;
  logic                   push;

  rob_ctl_t               cell_ctl;
  logic [WINDOW-1:0]      cell_vld;
  logic [HANDLE_BITS-1:0] cell_hdl [WINDOW];
  logic [WINDOW-1:0]      hit_vec;

  // handle width conversion, zero padded both ways
  assign in_hdl_ext   = {{HANDLE_BITS{1'b0}}, in_chunk_handle};
  assign in_hdl_k     = in_hdl_ext[HANDLE_BITS-1:0];
  assign pend_hdl_ext = {{HDL_W{1'b0}}, pend_hdl_r};

  assign out_free = !out_valid_r || !out_stall;
  assign go       = !pend_vld_r || out_free;

  assign ahead   = it_seq_r - ne_r;
  assign in_win  = (ahead < SEQ_W'(WINDOW));
  assign wrapped = (it_seq_r < ne_r);

  // slot offset from the head; past the 2^32 wrap the slot is the number itself
  assign pos_diff = {1'b0, it_seq_r[SLOT_W-1:0]} - {1'b0, ne_slot_r};
  assign pos_wrap = pos_diff[SLOT_W] ? pos_diff + (SLOT_W+1)'(WINDOW) : pos_diff;
  assign pos      = wrapped ? pos_wrap[SLOT_W-1:0] : ahead[SLOT_W-1:0];

  assign dup      = |hit_vec;
  assign aligned  = (head_slot_r == ne_slot_r);
  assign head_vld = cell_vld[0];
  assign run_more = head_vld && (cnt_r < CNT_W'(MAX_RESULTS));

  assign can_close = (state_r == S_DRAIN) && go && aligned && !run_more;
  assign in_stall  = !((state_r == S_IDLE) || can_close);
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    produce   = 1'b0;
    finish    = 1'b0;
    advance   = 1'b0;
    shift     = 1'b0;
    park      = 1'b0;
    clr_head  = 1'b0;
    res_hdl   = it_hdl_r;
    res_seq   = it_seq_r;
    res_st    = ST_RELEASED;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (go) begin
          if (in_win) begin
            if (dup) begin
              produce = 1'b1;
              res_st  = ST_DUP;
            end else if (ahead == '0) begin
              produce = 1'b1;
              advance = 1'b1;
              shift   = 1'b1;
            end else begin
              park = 1'b1;
            end
          end else begin
            produce = 1'b1;
            res_st  = ahead[SEQ_W-1] ? ST_DUP : ST_BEYOND;
          end
          cnt_nxt   = produce ? CNT_W'(1) : '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (go) begin
          if (!aligned) begin
            shift = 1'b1;
          end else if (run_more) begin
            produce  = 1'b1;
            res_hdl  = cell_hdl[0];
            res_seq  = ne_r;
            clr_head = 1'b1;
            shift    = 1'b1;
            advance  = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end else begin
            finish    = 1'b1;
            state_nxt = in_fire ? S_EVAL : S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // slot of next_expected restarts at zero when the number wraps
  always_comb begin
    ne_slot_nxt = ne_slot_r;
    if (advance) begin
      if (ne_r == '1) begin
        ne_slot_nxt = '0;
      end else if (ne_slot_r == SLOT_W'(WINDOW - 1)) begin
        ne_slot_nxt = '0;
      end else begin
        ne_slot_nxt = ne_slot_r + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    head_slot_nxt = head_slot_r;
    if (shift) begin
      if (head_slot_r == SLOT_W'(WINDOW - 1)) begin
        head_slot_nxt = '0;
      end else begin
        head_slot_nxt = head_slot_r + SLOT_W'(1);
      end
    end
  end

  // the waiting result goes out once the next one or the end of the run is known
  assign push = pend_vld_r && (produce || finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ne_r        <= '0;
      ne_slot_r   <= '0;
      head_slot_r <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_slot_r   <= ne_slot_nxt;
      head_slot_r <= head_slot_nxt;
      cnt_r       <= cnt_nxt;
      if (advance) begin
        ne_r <= ne_r + SEQ_W'(1);
      end
      if (produce) begin
        pend_vld_r <= 1'b1;
      end else if (finish) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_seq_r <= in_seq_number;
      it_hdl_r <= in_hdl_k;
    end
    if (produce) begin
      pend_hdl_r <= res_hdl;
      pend_seq_r <= res_seq;
      pend_st_r  <= res_st;
    end
    if (push) begin
      out_hdl_r  <= pend_hdl_ext[HDL_W-1:0];
      out_seq_r  <= pend_seq_r;
      out_st_r   <= pend_st_r;
      out_last_r <= finish;
    end
  end

  assign cell_ctl.shift = shift;
  assign cell_ctl.park  = park;

  // ring: each cell takes its upper neighbor on a shift, the head wraps to the tail
  for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
    logic                   nb_vld;
    logic [HANDLE_BITS-1:0] nb_hdl;
    if (gi == WINDOW - 1) begin : g_tail
      assign nb_vld = cell_vld[0] & ~clr_head;
      assign nb_hdl = cell_hdl[0];
    end else begin : g_body
      assign nb_vld = cell_vld[gi+1];
      assign nb_hdl = cell_hdl[gi+1];
    end
    rob_cell #(
      .IDX         (gi),
      .SLOT_W      (SLOT_W),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .park_pos (pos),
      .park_hdl (it_hdl_r),
      .nb_vld   (nb_vld),
      .nb_hdl   (nb_hdl),
      .vld      (cell_vld[gi]),
      .hdl      (cell_hdl[gi]),
      .hit      (hit_vec[gi])
    );
  end

  assign out_valid           = out_valid_r;
  assign out_released_handle = out_hdl_r;
  assign out_released_seq    = out_seq_r;
  assign out_status          = out_st_r;
  assign out_last_of_run     = out_last_r;

endmodule

>>> hdl/rob_cell.sv
// rob_cell: one window slot of the reorder ring, holds a valid bit and a handle
// depends on rob_pkg for the control struct

module rob_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned SLOT_W      = 4,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rob_pkg::rob_ctl_t      ctl,
  input  logic [SLOT_W-1:0]      park_pos,
  input  logic [HANDLE_BITS-1:0] park_hdl,
  input  logic                   nb_vld,
  input  logic [HANDLE_BITS-1:0] nb_hdl,
  output logic                   vld,
  output logic [HANDLE_BITS-1:0] hdl,
  output logic                   hit
);

  logic                   vld_r;
  logic                   vld_nxt;
  logic [HANDLE_BITS-1:0] hdl_r;
  logic                   match;

  assign match = (park_pos == SLOT_W'(IDX));
  assign hit   = vld_r & match;
  assign vld   = vld_r;
  assign hdl   = hdl_r;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.shift) begin
      vld_nxt = nb_vld;
    end else if (ctl.park && match) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hdl_r <= nb_hdl;
    end else if (ctl.park && match) begin
      hdl_r <= park_hdl;
    end
  end

endmodule

>>> hdl/rob_chk.sv
// rob_chk: port-level checker for the in-order release reorder buffer, with its bind
// depends on rob_pkg; attaches to in_order_release_reorder_buffer

module rob_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rob_pkg::HDL_W-1:0]     out_released_handle,
  input logic [rob_pkg::SEQ_W-1:0]     out_released_seq,
  input logic [rob_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_last_of_run
);

  import rob_pkg::*;

  logic [SEQ_W-1:0] exp_r;

  // next sequence number that a release must carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else if (out_valid && !out_stall && out_status == ST_RELEASED) begin
      exp_r <= exp_r + SEQ_W'(1);
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_released_handle)
      && $stable(out_released_seq) && $stable(out_status) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_release_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RELEASED |-> out_released_seq == exp_r)
    else $error("release out of sequence order");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is being evaluated");

endmodule

bind in_order_release_reorder_buffer rob_chk u_rob_chk (.*);

>>> test/rob_release_checker.sv
// rob_release_checker: watches both channels of the reorder buffer, predicts the in-order
// releases and drops for every accepted chunk and compares each result transfer
// depends on rob_pkg for widths and status codes

module rob_release_checker #(
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rob_pkg::SEQ_W-1:0]    in_seq_number,
  input  logic [rob_pkg::HDL_W-1:0]    in_chunk_handle,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rob_pkg::HDL_W-1:0]    out_released_handle,
  input  logic [rob_pkg::SEQ_W-1:0]    out_released_seq,
  input  logic [rob_pkg::STATUS_W-1:0] out_status,
  input  logic                         out_last_of_run,
  output int                           fail_count,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import rob_pkg::*;

  localparam logic [63:0] HANDLE_MASK = (64'd2 << (HANDLE_BITS - 1)) - 64'd1;

  typedef struct {
    logic [HDL_W-1:0] handle;
    logic [SEQ_W-1:0] seq;
    status_t          status;
    logic             last;
  } freed_chunk_t;

  freed_chunk_t     pending_releases[$];
  logic [SEQ_W-1:0] next_seq;
  logic [63:0]      slot_handle[WINDOW];
  logic             slot_full[WINDOW];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // works out every result one accepted chunk causes, in order
  task automatic sort_chunk(input logic [SEQ_W-1:0] seq, input logic [HDL_W-1:0] hdl);
    freed_chunk_t batch[$];
    logic [63:0]  h;
    logic [SEQ_W-1:0] ahead;
    int unsigned  slot;
    int unsigned  head;
    h     = {48'd0, hdl} & HANDLE_MASK;
    ahead = seq - next_seq;
    slot  = seq % WINDOW;
    if (ahead < WINDOW) begin
      if (slot_full[slot]) begin
        batch.push_back('{h[HDL_W-1:0], seq, ST_DUP, 1'b0});
      end else if (ahead == '0) begin
        batch.push_back('{h[HDL_W-1:0], seq, ST_RELEASED, 1'b0});
        next_seq++;
      end else begin
        slot_handle[slot] = h;
        slot_full[slot]   = 1'b1;
      end
    end else if (!ahead[SEQ_W-1]) begin
      batch.push_back('{h[HDL_W-1:0], seq, ST_BEYOND, 1'b0});
    end else begin
      // behind next_seq: already passed
      batch.push_back('{h[HDL_W-1:0], seq, ST_DUP, 1'b0});
    end
    // drain the consecutive run, capped per chunk; the rest waits for later chunks
    while (batch.size() < MAX_RESULTS) begin
      head = next_seq % WINDOW;
      if (!slot_full[head]) break;
      batch.push_back('{slot_handle[head][HDL_W-1:0], next_seq, ST_RELEASED, 1'b0});
      slot_full[head] = 1'b0;
      next_seq++;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_releases.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    freed_chunk_t want;
    if (!rst_n) begin
      next_seq = '0;
      for (int i = 0; i < WINDOW; i++) slot_full[i] = 1'b0;
      pending_releases.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) sort_chunk(in_seq_number, in_chunk_handle);
      if (out_valid && !out_stall) begin
        if (pending_releases.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer handle %h seq %h status %0d",
                                    out_released_handle, out_released_seq, out_status));
        end else begin
          want = pending_releases.pop_front();
          if (out_released_handle !== want.handle)
            report_mismatch($sformatf("seq %h: handle %h, want %h",
                                      want.seq, out_released_handle, want.handle));
          if (out_released_seq !== want.seq)
            report_mismatch($sformatf("seq %h, want %h", out_released_seq, want.seq));
          if (out_status !== want.status)
            report_mismatch($sformatf("seq %h: status %0d, want %0d",
                                      want.seq, out_status, want.status));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("seq %h: last_of_run %b, want %b",
                                      want.seq, out_last_of_run, want.last));
        end
      end
      outstanding <= pending_releases.size();
    end
  end

endmodule

>>> test/tb_in_order_release_reorder_buffer.sv
// tb_in_order_release_reorder_buffer: drives shuffled chunk runs and error cases into the
// reorder buffer with random gaps and output stalls and gives the verdict
// depends on rob_pkg, in_order_release_reorder_buffer and rob_release_checker

module tb_in_order_release_reorder_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import rob_pkg::*;

  localparam int unsigned WINDOW      = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned ITEMS       = 350;
  localparam int unsigned DRAIN_TAIL  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SEQ_W-1:0]    in_seq_number = '0;
  logic [HDL_W-1:0]    in_chunk_handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HDL_W-1:0]    out_released_handle;
  logic [SEQ_W-1:0]    out_released_seq;
  logic [STATUS_W-1:0] out_status;
  logic                out_last_of_run;
  int                  fail_count;
  int                  outstanding;

  int unsigned         items_sent = 0;
  int unsigned         burst_left = 0;
  bit                  gaps_on = 1'b1;
  logic [SEQ_W-1:0]    stream_pos = '0;

  in_order_release_reorder_buffer #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_seq_number       (in_seq_number),
    .in_chunk_handle     (in_chunk_handle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_released_handle (out_released_handle),
    .out_released_seq    (out_released_seq),
    .out_status          (out_status),
    .out_last_of_run     (out_last_of_run)
  );

  rob_release_checker #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_seq_number       (in_seq_number),
    .in_chunk_handle     (in_chunk_handle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_released_handle (out_released_handle),
    .out_released_seq    (out_released_seq),
    .out_status          (out_status),
    .out_last_of_run     (out_last_of_run),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall pattern: one of four styles, redrawn at random
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;
  always @(negedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) stall_style <= $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: begin
          if ($urandom_range(0, 11) == 0) stall_left <= $urandom_range(1, 20);
          out_stall <= 1'b0;
        end
        default: out_stall <= cycle_cnt[2] & cycle_cnt[0];
      endcase
    end
  end

  function automatic logic [HDL_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return HDL_W'($urandom);
    endcase
  endfunction

  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    in_valid        <= 1'b0;
    in_seq_number   <= $urandom;
    in_chunk_handle <= HDL_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_chunk(input logic [SEQ_W-1:0] seq, input logic [HDL_W-1:0] hdl);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_seq_number   <= seq;
    in_chunk_handle <= hdl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 8));
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop valid and hold off until every expected result has transferred
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_chunk(stream_pos + 32'd32 + $urandom_range(0, 32'h7FFF_FF00), pick_handle());
      1: send_chunk(stream_pos - 32'd1 - $urandom_range(0, 40), pick_handle());
      2: send_chunk(stream_pos - 32'd1 - $urandom_range(0, 32'h7FFF_FF00), pick_handle());
      default: send_chunk($urandom, pick_handle());
    endcase
  endtask

  // one run of consecutive numbers in shuffled order, sometimes with the head held back
  task automatic send_block();
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] swap;
    logic [SEQ_W-1:0] held;
    int unsigned      len;
    int unsigned      k;
    bit               hold;
    len = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 12);
    for (int j = 0; j < len; j++) order.push_back(stream_pos + SEQ_W'(j));
    for (int j = len - 1; j > 0; j--) begin
      k        = $urandom_range(0, j);
      swap     = order[j];
      order[j] = order[k];
      order[k] = swap;
    end
    hold = (len > 1) && ($urandom_range(0, 3) == 0);
    held = '0;
    if (hold) begin
      for (int j = 0; j < order.size(); j++) begin
        if (order[j] == stream_pos) begin
          held = order[j];
          order.delete(j);
          break;
        end
      end
    end
    foreach (order[j]) begin
      send_chunk(order[j], pick_handle());
      // resend something already seen: parked gives a duplicate, released is stale
      if (j > 0 && $urandom_range(0, 9) == 0)
        send_chunk(order[$urandom_range(0, j)], pick_handle());
    end
    if (hold) begin
      repeat ($urandom_range(1, 3)) send_noise();
      send_chunk(held, pick_handle());
    end
    stream_pos += SEQ_W'(len);
  endtask

  initial begin
    int unsigned next_pause;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: in order, stale, park, duplicate slot, window edges, full run
    send_chunk(32'd0, 16'h0000);
    send_chunk(32'd0, 16'hFFFF);
    send_chunk(32'd2, 16'h1234);
    send_chunk(32'd2, 16'hABCD);
    send_chunk(32'd16, 16'h5A5A);
    send_chunk(32'd17, 16'hA5A5);
    send_chunk(32'h8000_0000, 16'h00FF);
    send_chunk(32'h8000_0001, 16'hFF00);
    send_chunk(32'hFFFF_FFFF, 16'h8001);
    for (int s = 15; s >= 3; s--) send_chunk(SEQ_W'(s), pick_handle());
    send_chunk(32'd1, 16'hFFFF);
    stream_pos = 32'd17;
    wait_drained();

    next_pause = items_sent + 80;
    while (items_sent < ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) send_block();
      else send_noise();
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause = items_sent + 80;
      end
    end
    wait_drained();

    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
